// ----- rtl/core/tlg_pkg.sv -----
`timescale 1ns / 1ps

package tlg_pkg;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  GRID_SIZE_RESET = 8'd100;

    // neighbour counts of the life rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] cell_x;
        logic [6:0] cell_y;
        logic       cell_value;
    } req_t;

    typedef struct packed {
        logic read_value;
        logic out_of_range;
    } rsp_t;

    // one column of the three-row window: row above, row in work, row below
    typedef struct packed {
        logic up;
        logic mid;
        logic down;
    } col_t;

endpackage

// ----- rtl/core/tlg_cell.sv -----
`timescale 1ns / 1ps

module tlg_cell (
    input  logic          clk,
    input  logic          shift,
    input  logic          active,
    input  logic          down,
    input  tlg_pkg::col_t left,
    input  tlg_pkg::col_t right,
    output tlg_pkg::col_t col,
    output logic          new_bit
);

    logic       up_reg;
    logic       mid_reg;
    logic [3:0] count;

    // move the window one row down
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= down;
        end
    end

    assign col.up   = up_reg;
    assign col.mid  = mid_reg;
    assign col.down = down;

    assign count = 4'(left.up) + 4'(left.mid) + 4'(left.down)
                 + 4'(right.up) + 4'(right.mid) + 4'(right.down)
                 + 4'(up_reg) + 4'(down);

    // columns beyond the active width keep their value
    assign new_bit = active ? ((count == tlg_pkg::BIRTH_COUNT)
                               || ((count == tlg_pkg::KEEP_COUNT) && mid_reg))
                            : mid_reg;

endmodule

// ----- rtl/core/tlg_cell_row.sv -----
`timescale 1ns / 1ps

module tlg_cell_row #(
    parameter int MAX_WIDTH = 128,
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8
) (
    input  logic                 clk,
    input  logic                 shift,
    input  logic [WCW-1:0]       width,
    input  logic [MAX_WIDTH-1:0] down_row,
    output logic [MAX_WIDTH-1:0] new_row
);

    localparam int XW = $clog2(MAX_WIDTH);

    tlg_pkg::col_t            col [MAX_WIDTH];
    tlg_pkg::col_t            col_last;
    logic [WCW-1:0]           last_col;

    assign last_col = width - WCW'(1);
    assign col_last = col[XW'(last_col)];

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_cell
        localparam logic [WCW-1:0] IDX = WCW'(i);
        tlg_pkg::col_t left;
        tlg_pkg::col_t right;

        // wrap at the configured width, not at the array edge
        if (i == 0)
        begin : g_first
            assign left = col_last;
        end
        else
        begin : g_inner_left
            assign left = col[i-1];
        end

        if (i == MAX_WIDTH - 1)
        begin : g_last
            assign right = col[0];
        end
        else
        begin : g_inner_right
            assign right = (IDX == last_col) ? col[0] : col[i+1];
        end

        tlg_cell u_cell (
            .clk     (clk),
            .shift   (shift),
            .active  (IDX < width),
            .down    (down_row[i]),
            .left    (left),
            .right   (right),
            .col     (col[i]),
            .new_bit (new_row[i])
        );
    end

endmodule

// ----- rtl/core/toroidal_life_generation_core.sv -----
`timescale 1ns / 1ps
// Write: the cell is written at the transfer, then the result is loaded; read: the row is
// registered, its bit picked in ST_READ, then the result is loaded; both free the input after
// that. Advance: one grid row per cycle through the single read port of the row memory and the chain of column cells.
// One item is in work at a time; a waiting result does not hold off the next transfer.
// Reset: asynchronous, active low; afterwards a clearing pass over all MAX_HEIGHT rows zeroes
// the grid with input stalled, and both size registers return to 100.
module toroidal_life_generation_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  tlg_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output tlg_pkg::rsp_t                       rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tlg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int AW  = $clog2(MAX_HEIGHT);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8;
    localparam int SQW = HCW + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic [SQW-1:0]                seq_reg, seq_next;
    logic [SQW-1:0]                dseq_reg, dseq_next;
    logic                          dv_reg, dv_next;
    logic [6:0]                    x_reg, x_next;
    tlg_pkg::rsp_t                 res_reg, res_next;
    tlg_pkg::rsp_t                 out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tlg_pkg::CFG_DATA_W-1:0] width_reg, width_next;
    logic [tlg_pkg::CFG_DATA_W-1:0] height_reg, height_next;

    logic [MAX_WIDTH-1:0]          grid_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]          rd_data_reg;
    logic [MAX_WIDTH-1:0]          first_row_reg;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic [MAX_WIDTH-1:0]          mem_wr_mask;
    logic [MAX_WIDTH-1:0]          mem_wr_data;
    logic                          mem_rd_en;
    logic [AW-1:0]                 mem_rd_addr;

    logic [WCW-1:0]                w_ext, w_eff;
    logic [HCW-1:0]                h_ext, h_eff;
    logic [SQW-1:0]                h_plus1;
    logic                          in_range;
    logic                          sweep_issue;
    logic [MAX_WIDTH-1:0]          down_row;
    logic [MAX_WIDTH-1:0]          new_row;

    // clamp the size registers to 1..MAX
    assign w_ext = WCW'(width_reg);
    assign h_ext = HCW'(height_reg);
    assign w_eff = (width_reg == '0) ? WCW'(1)
                 : ((w_ext > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_ext);
    assign h_eff = (height_reg == '0) ? HCW'(1)
                 : ((h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext);
    assign h_plus1 = SQW'(h_eff) + SQW'(1);

    assign in_range = (WCW'(req.cell_x) < w_eff) && (HCW'(req.cell_y) < h_eff);

    assign req_stall   = (state_reg != ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign rsp         = out_reg;
    assign cfg_ready   = 1'b1;
    assign sweep_issue = (seq_reg <= h_plus1);

    // row after the last one is the original first row, saved before it was overwritten
    assign down_row = (dseq_reg == h_plus1) ? first_row_reg : rd_data_reg;

    tlg_cell_row #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cell_row (
        .clk      (clk),
        .shift    (dv_reg),
        .width    (w_eff),
        .down_row (down_row),
        .new_row  (new_row)
    );

    // memory port control
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_mask = '1;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
            end
            ST_IDLE:
            begin
                if (req_valid && in_range)
                begin
                    if (req.req_type == tlg_pkg::REQ_WRITE)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(req.cell_y);
                        mem_wr_mask = MAX_WIDTH'(1) << XW'(req.cell_x);
                        mem_wr_data = {MAX_WIDTH{req.cell_value}};
                    end
                    else if (req.req_type == tlg_pkg::REQ_READ)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req.cell_y);
                    end
                end
            end
            ST_SWEEP:
            begin
                // row h-1 first, then rows 0 .. h-1
                mem_rd_en   = (seq_reg <= SQW'(h_eff));
                mem_rd_addr = (seq_reg == '0) ? AW'(h_eff - HCW'(1))
                                              : AW'(seq_reg - SQW'(1));
                mem_wr_en   = dv_reg && (dseq_reg >= SQW'(2));
                mem_wr_addr = AW'(dseq_reg - SQW'(2));
                mem_wr_data = new_row;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                if (mem_wr_mask[i])
                begin
                    grid_mem[mem_wr_addr][i] <= mem_wr_data[i];
                end
            end
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= grid_mem[mem_rd_addr];
        end
    end

    // keep the original first row for the wrap at the bottom
    always_ff @(posedge clk)
    begin
        if (dv_reg && (dseq_reg == SQW'(1)))
        begin
            first_row_reg <= rd_data_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        seq_next       = seq_reg;
        dseq_next      = dseq_reg;
        dv_next        = 1'b0;
        x_next         = x_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        width_next     = width_reg;
        height_next    = height_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                tlg_pkg::CFG_GRID_WIDTH:  width_next  = cfg_data;
                tlg_pkg::CFG_GRID_HEIGHT: height_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_HEIGHT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    x_next                = req.cell_x;
                    res_next.read_value   = 1'b0;
                    res_next.out_of_range = 1'b0;
                    case (req.req_type)
                        tlg_pkg::REQ_WRITE:
                        begin
                            res_next.out_of_range = !in_range;
                            state_next            = ST_RESULT;
                        end
                        tlg_pkg::REQ_READ:
                        begin
                            res_next.out_of_range = !in_range;
                            state_next            = in_range ? ST_READ : ST_RESULT;
                        end
                        tlg_pkg::REQ_ADVANCE:
                        begin
                            seq_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.read_value = rd_data_reg[XW'(x_reg)];
                state_next          = ST_RESULT;
            end
            ST_SWEEP:
            begin
                if (sweep_issue)
                begin
                    seq_next  = seq_reg + SQW'(1);
                    dv_next   = 1'b1;
                    dseq_next = seq_reg;
                end
                if (dv_reg && (dseq_reg == h_plus1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // load the output register once it is free or being drained
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            seq_reg       <= '0;
            dseq_reg      <= '0;
            dv_reg        <= 1'b0;
            x_reg         <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= tlg_pkg::GRID_SIZE_RESET;
            height_reg    <= tlg_pkg::GRID_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            seq_reg       <= seq_next;
            dseq_reg      <= dseq_next;
            dv_reg        <= dv_next;
            x_reg         <= x_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    a_no_row_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("row written and read in the same cycle");

    a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP) && mem_wr_en) |-> (HCW'(mem_wr_addr) < h_eff))
        else $error("generation step wrote a row outside the grid");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result presented without a finished request");

    a_window_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == ST_SWEEP))
        else $error("row window shifted outside a generation step");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int GRID_COLS    = 128;
    localparam int GRID_ROWS    = 128;
    localparam int GRID_CELLS   = GRID_COLS * GRID_ROWS;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = GRID_ROWS + 16;
    localparam bit SENDER       = 1'b0;
    localparam bit RECEIVER     = 1'b1;

    localparam logic [1:0]                      REQ_UNUSED      = 2'd3;
    localparam logic [tlg_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [tlg_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    tlg_pkg::req_t                   req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b1;
    tlg_pkg::rsp_t                   rsp;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tlg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tlg_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // predicted grid: two planes, front_plane marks the current generation
    bit [GRID_CELLS-1:0]            life_plane [2];
    bit                             front_plane = 1'b0;
    bit [tlg_pkg::CFG_DATA_W-1:0]   width_reg   = tlg_pkg::GRID_SIZE_RESET;
    bit [tlg_pkg::CFG_DATA_W-1:0]   height_reg  = tlg_pkg::GRID_SIZE_RESET;

    tlg_pkg::rsp_t          replies_due [$];
    int                     errors      = 0;
    int                     cycles      = 0;
    int                     quiet_left [2] = '{0, 0};

    toroidal_life_generation_core #(
        .MAX_WIDTH  (GRID_COLS),
        .MAX_HEIGHT (GRID_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int clamp_size(bit [tlg_pkg::CFG_DATA_W-1:0] value, int limit);
        if (value < 1)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic bit live_at(int x, int y);
        return life_plane[front_plane][y * GRID_COLS + x];
    endfunction

    function automatic void step_generation();
        int cols, rows, x, y, up, down, left, right, n;
        bit back;
        cols = clamp_size(width_reg, GRID_COLS);
        rows = clamp_size(height_reg, GRID_ROWS);
        back = ~front_plane;
        // cells beyond the active size carry over untouched
        life_plane[back] = life_plane[front_plane];
        for (y = 0; y < rows; y++)
        begin
            up   = (y == 0) ? rows - 1 : y - 1;
            down = (y + 1 == rows) ? 0 : y + 1;
            for (x = 0; x < cols; x++)
            begin
                left  = (x == 0) ? cols - 1 : x - 1;
                right = (x + 1 == cols) ? 0 : x + 1;
                n = live_at(left, up) + live_at(x, up) + live_at(right, up)
                  + live_at(left, y) + live_at(right, y)
                  + live_at(left, down) + live_at(x, down) + live_at(right, down);
                life_plane[back][y * GRID_COLS + x] =
                    (n == tlg_pkg::BIRTH_COUNT)
                    || (n == tlg_pkg::KEEP_COUNT && live_at(x, y));
            end
        end
        front_plane = back;
    endfunction

    function automatic tlg_pkg::rsp_t life_apply_request(tlg_pkg::req_t item);
        tlg_pkg::rsp_t reply;
        int            cols, rows, idx;
        reply = '0;
        cols  = clamp_size(width_reg, GRID_COLS);
        rows  = clamp_size(height_reg, GRID_ROWS);
        case (item.req_type)
            tlg_pkg::REQ_WRITE, tlg_pkg::REQ_READ:
            begin
                if (item.cell_x >= cols || item.cell_y >= rows)
                    reply.out_of_range = 1'b1;
                else
                begin
                    idx = item.cell_y * GRID_COLS + item.cell_x;
                    if (item.req_type == tlg_pkg::REQ_WRITE)
                        life_plane[front_plane][idx] = item.cell_value;
                    else
                        reply.read_value = life_plane[front_plane][idx];
                end
            end
            tlg_pkg::REQ_ADVANCE:
                step_generation();
            default:
                ;
        endcase
        return reply;
    endfunction

    // zero-wait stretches now and then, otherwise a random pause before the next item
    function automatic int draw_pause(bit side);
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic tlg_pkg::req_t make_req(logic [1:0] kind, int x, int y, bit value);
        tlg_pkg::req_t item;
        item.req_type   = kind;
        item.cell_x     = 7'(x);
        item.cell_y     = 7'(y);
        item.cell_value = value;
        return item;
    endfunction

    function automatic tlg_pkg::req_t random_request();
        tlg_pkg::req_t item;
        int            cols, rows, pick;
        cols = clamp_size(width_reg, GRID_COLS);
        rows = clamp_size(height_reg, GRID_ROWS);
        item = make_req(tlg_pkg::REQ_WRITE, $urandom_range(0, cols - 1),
                        $urandom_range(0, rows - 1), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            item.req_type = tlg_pkg::REQ_WRITE;
        else if (pick < 70)
            item.req_type = tlg_pkg::REQ_READ;
        else if (pick < 82)
            item.req_type = tlg_pkg::REQ_ADVANCE;
        else
        begin
            // noise: any coordinate, a write, a read or the unused code
            item.cell_x   = 7'($urandom_range(0, 127));
            item.cell_y   = 7'($urandom_range(0, 127));
            item.req_type = (pick < 88) ? tlg_pkg::REQ_WRITE
                          : (pick < 94) ? tlg_pkg::REQ_READ : REQ_UNUSED;
        end
        return item;
    endfunction

    function automatic bit [tlg_pkg::CFG_DATA_W-1:0] extreme_size();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd128;
            default: return 8'd255;
        endcase
    endfunction

    task automatic send_request(input tlg_pkg::req_t item);
        int pause;
        pause = draw_pause(SENDER);
        if (pause > 0)
        begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        replies_due.push_back(life_apply_request(item));
    endtask

    // drop valid and hold until every expected result has been taken
    task automatic await_replies();
        req_valid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0);
    endtask

    task automatic cfg_transfer(input logic [tlg_pkg::CFG_INDEX_W-1:0] index,
                                input logic [tlg_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            tlg_pkg::CFG_GRID_WIDTH:  width_reg  = value;
            tlg_pkg::CFG_GRID_HEIGHT: height_reg = value;
            default:                  ;
        endcase
    endtask

    // unmapped writes go last so that any aliasing onto a size shows up
    task automatic program_grid(input logic [tlg_pkg::CFG_DATA_W-1:0] cols,
                                input logic [tlg_pkg::CFG_DATA_W-1:0] rows,
                                input bit with_spare);
        cfg_transfer(tlg_pkg::CFG_GRID_WIDTH, cols);
        cfg_transfer(tlg_pkg::CFG_GRID_HEIGHT, rows);
        if (with_spare)
        begin
            cfg_transfer(CFG_UNMAPPED_LO, 8'($urandom_range(0, 255)));
            cfg_transfer(CFG_UNMAPPED_HI, 8'($urandom_range(0, 255)));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_request(make_req(tlg_pkg::REQ_READ, 0, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 99, 99, 1'b0));
        send_request(make_req(tlg_pkg::REQ_WRITE, 99, 99, 1'b1));
        send_request(make_req(tlg_pkg::REQ_READ, 99, 99, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 100, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_WRITE, 0, 100, 1'b1));
        send_request(make_req(tlg_pkg::REQ_READ, 127, 127, 1'b1));
        send_request(make_req(REQ_UNUSED, 127, 127, 1'b1));
    endtask

    // live cells on all four corners wrap into one another
    task automatic test_small_torus();
        await_replies();
        program_grid(8'd4, 8'd3, 1'b0);
        send_request(make_req(tlg_pkg::REQ_WRITE, 0, 0, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 3, 0, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 0, 2, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 3, 2, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 1, 1, 1'b0));
        send_request(make_req(tlg_pkg::REQ_ADVANCE, 0, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 0, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 1, 1, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 0, 1, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 99, 99, 1'b0));
    endtask

    // sizes beyond either end clamp; the far cell is read back after an advance
    task automatic test_clamped_sizes();
        await_replies();
        program_grid(8'd255, 8'd0, 1'b1);
        send_request(make_req(tlg_pkg::REQ_WRITE, 127, 0, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 126, 0, 1'b1));
        send_request(make_req(tlg_pkg::REQ_WRITE, 0, 0, 1'b1));
        send_request(make_req(tlg_pkg::REQ_ADVANCE, 0, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 127, 0, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 0, 1, 1'b0));
        await_replies();
        program_grid(8'd128, 8'd128, 1'b0);
        send_request(make_req(tlg_pkg::REQ_READ, 99, 99, 1'b0));
        send_request(make_req(tlg_pkg::REQ_READ, 127, 127, 1'b0));
    endtask

    task automatic test_random_generations();
        int sent, run, pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            await_replies();
            pick = $urandom_range(0, 9);
            if (pick < 6)
                program_grid(8'($urandom_range(1, 16)), 8'($urandom_range(1, 12)),
                             pick == 0);
            else if (pick < 8)
                program_grid(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'b1);
            else
                program_grid(extreme_size(), extreme_size(), pick == 9);
            run = $urandom_range(30, 90);
            repeat (run)
            begin
                send_request(random_request());
                sent++;
                if ($urandom_range(0, 49) == 0)
                    await_replies();
            end
        end
    endtask

    initial
    begin
        int hold;
        forever
        begin
            hold = draw_pause(RECEIVER);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && rsp_valid && !rsp_stall));
        end
    end

    always @(posedge clk)
    begin
        tlg_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: result %b with none expected", $time, rsp);
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    errors++;
                    $display("%0t: read_value expected %0b got %0b",
                             $time, want.read_value, rsp.read_value);
                end
                if (rsp.out_of_range !== want.out_of_range)
                begin
                    errors++;
                    $display("%0t: out_of_range expected %0b got %0b",
                             $time, want.out_of_range, rsp.out_of_range);
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_small_torus();
        test_clamped_sizes();
        test_random_generations();
        await_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- toroidal_life_generation_core.f -----
rtl/core/tlg_pkg.sv
rtl/core/tlg_cell.sv
rtl/core/tlg_cell_row.sv
rtl/core/toroidal_life_generation_core.sv
tb/sv/tb_top.sv
